// ----- hw/rtl/packbits_segment_decoder_macros.svh -----
// Assertion macros for the PackBits segment decoder.
`ifndef PACKBITS_SEGMENT_DECODER_MACROS_SVH
`define PACKBITS_SEGMENT_DECODER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PSD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psd: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PSD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psd: next-cycle check failed");

`endif

// ----- hw/rtl/psd_pkg.sv -----
// Shared types and constants of the PackBits segment decoder.
package psd_pkg;

  localparam int MAX_RUN = 128;
  localparam int KEEP_W = $clog2(MAX_RUN + 1);

  localparam logic [7:0] HDR_NOP = 8'd128;
  localparam logic [8:0] REPEAT_BASE = 9'd257;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE = 2'd1;
  localparam logic [1:0] CNT_TWO = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_REPEAT
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       segment_start;
    logic       segment_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] byte_count;
    logic       last_of_run;
    logic       segment_done;
    logic       length_error;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic emit;
    logic status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic start_emit;
    logic start_end;
    logic emit_last;
  } dp_status_t;

endpackage

// ----- hw/rtl/psd_if.sv -----
// Channel interfaces of the PackBits segment decoder.
interface psd_in_if import psd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface psd_out_if import psd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface psd_cfg_if import psd_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/psd_ctrl.sv -----
// Sequencing state machine of the PackBits segment decoder.
module psd_ctrl import psd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (status.start_emit) begin
            state_next = ST_EMIT;
          end else if (status.start_end) begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_EMIT: begin
        if (status.slot_free && status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (status.slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      ST_EMIT: cmd.emit = status.slot_free;
      ST_STATUS: cmd.status = status.slot_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ----- hw/rtl/psd_datapath.sv -----
// Decoder state, run counters, length check and result register.
module psd_datapath import psd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  input  in_item_t    in_item,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_item,
  output dp_status_t  status
);

  logic [31:0]       target_len;
  phase_t            phase;
  logic [7:0]        literal_left;
  logic [7:0]        repeat_len;
  logic [31:0]       produced_count;
  logic              overrun_seen;
  logic [KEEP_W-1:0] keep;
  logic [7:0]        hold_byte;
  logic              hold_end;

  phase_t            base_phase;
  logic [7:0]        base_ll;
  logic [7:0]        base_rl;
  logic [31:0]       base_prod;
  logic              base_ovr;
  logic [7:0]        run_len;
  logic [31:0]       room;
  logic              short_room;
  logic [KEEP_W-1:0] keep_acc;
  phase_t            phase_next;
  logic [7:0]        ll_next;
  logic [7:0]        rl_next;
  logic [7:0]        ll_dec;

  logic [1:0]        emit_cnt;
  logic [31:0]       prod_emit;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;

  always_comb begin
    base_phase = in_item.segment_start ? PH_HEADER : phase;
    base_ll = in_item.segment_start ? 8'd0 : literal_left;
    base_rl = in_item.segment_start ? 8'd0 : repeat_len;
    base_prod = in_item.segment_start ? 32'd0 : produced_count;
    base_ovr = in_item.segment_start ? 1'b0 : overrun_seen;
    ll_dec = base_ll - 8'd1;

    run_len = 8'd0;
    phase_next = base_phase;
    ll_next = base_ll;
    rl_next = base_rl;
    case (base_phase)
      PH_LITERAL: begin
        run_len = 8'd1;
        ll_next = ll_dec;
        if (ll_dec == 8'd0) begin
          phase_next = PH_HEADER;
        end
      end
      PH_REPEAT: begin
        run_len = base_rl;
        rl_next = 8'd0;
        phase_next = PH_HEADER;
      end
      default: begin
        phase_next = PH_HEADER;
        if (in_item.in_byte > HDR_NOP) begin
          rl_next = 8'(REPEAT_BASE - {1'b0, in_item.in_byte});
          phase_next = PH_REPEAT;
        end else if (in_item.in_byte < HDR_NOP) begin
          ll_next = in_item.in_byte + 8'd1;
          phase_next = PH_LITERAL;
        end
      end
    endcase

    room = target_len - base_prod;
    short_room = room < {24'd0, run_len};
    keep_acc = short_room ? KEEP_W'(room) : KEEP_W'(run_len);
  end

  always_comb begin
    emit_cnt = (keep >= KEEP_W'(2)) ? CNT_TWO : CNT_ONE;
    prod_emit = produced_count + {30'd0, emit_cnt};
  end

  always_comb begin
    status.slot_free = slot_free;
    status.start_emit = keep_acc != '0;
    status.start_end = in_item.segment_end;
    status.emit_last = keep <= KEEP_W'(2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_len <= 32'd0;
    end else if (cfg_write) begin
      target_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      literal_left <= 8'd0;
      repeat_len <= 8'd0;
      produced_count <= 32'd0;
      overrun_seen <= 1'b0;
      keep <= '0;
      hold_end <= 1'b0;
    end else if (cmd.accept) begin
      phase <= in_item.segment_end ? PH_HEADER : phase_next;
      literal_left <= in_item.segment_end ? 8'd0 : ll_next;
      repeat_len <= in_item.segment_end ? 8'd0 : rl_next;
      produced_count <= base_prod;
      overrun_seen <= base_ovr | short_room;
      keep <= keep_acc;
      hold_end <= in_item.segment_end;
    end else if (cmd.emit) begin
      keep <= keep - KEEP_W'(emit_cnt);
      if (status.emit_last && hold_end) begin
        produced_count <= 32'd0;
        overrun_seen <= 1'b0;
      end else begin
        produced_count <= prod_emit;
      end
    end else if (cmd.status) begin
      produced_count <= 32'd0;
      overrun_seen <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hold_byte <= in_item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.byte_first <= hold_byte;
      out_item.byte_second <= (emit_cnt == CNT_TWO) ? hold_byte : 8'd0;
      out_item.byte_count <= emit_cnt;
      out_item.last_of_run <= status.emit_last;
      if (status.emit_last && hold_end) begin
        out_item.segment_done <= 1'b1;
        out_item.length_error <= overrun_seen || (prod_emit != target_len);
      end else begin
        out_item.segment_done <= prod_emit == target_len;
        out_item.length_error <= overrun_seen;
      end
    end else if (cmd.status) begin
      out_item.byte_first <= 8'd0;
      out_item.byte_second <= 8'd0;
      out_item.byte_count <= CNT_NONE;
      out_item.last_of_run <= 1'b1;
      out_item.segment_done <= 1'b1;
      out_item.length_error <= overrun_seen || (produced_count != target_len);
    end
  end

endmodule

// ----- hw/rtl/packbits_segment_decoder.sv -----
// Top level of the PackBits segment decoder.
// The first result of an item, or the status result of an item that keeps no bytes and
// carries segment_end, is registered in EMIT or STATUS, which wait for a free result slot.
// Only IDLE takes an item; an item with segment_end that keeps no bytes passes STATUS,
// and a data byte that keeps bytes passes EMIT, up to two of them per result.
// Reset (rst, synchronous): clears decoder state, the length register and the result slot.
module packbits_segment_decoder import psd_pkg::*; (
  input logic     clk,
  input logic     rst,
  psd_in_if.sink  enc,
  psd_out_if.source dec,
  psd_cfg_if.sink cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       in_ready;

  assign enc.ready = in_ready;
  assign cfg.ready = 1'b1;

  psd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (enc.valid),
    .status   (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  psd_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (enc.payload),
    .cfg_write (cfg.valid),
    .cfg_data  (cfg.data),
    .out_ready (dec.ready),
    .out_valid (dec.valid),
    .out_item  (dec.payload),
    .status    (st)
  );

`include "packbits_segment_decoder_macros.svh"

  `PSD_ASSERT_NXT(a_busy_after_run, clk, rst, enc.valid && enc.ready && (st.start_emit || st.start_end), !enc.ready)
  `PSD_ASSERT_IMP(a_status_only_final, clk, rst, dec.valid && dec.payload.byte_count == CNT_NONE, dec.payload.segment_done && dec.payload.last_of_run)
  `PSD_ASSERT_IMP(a_second_zero, clk, rst, dec.valid && dec.payload.byte_count != CNT_TWO, dec.payload.byte_second == 8'd0)

endmodule

// ----- test/packbits_segment_decoder_tb.sv -----
// Self-checking testbench of the PackBits segment decoder, with its own behavior predictor.
`timescale 1ns / 1ps

module packbits_segment_decoder_tb import psd_pkg::*; ();

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLDOFF_CYCLES = 250;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 60;
  localparam int unsigned STREAM_ITEMS = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;

  psd_in_if enc_if ();
  psd_out_if dec_if ();
  psd_cfg_if cfg_if ();

  packbits_segment_decoder DUT (
    .clk(clk),
    .rst(rst),
    .enc(enc_if),
    .dec(dec_if),
    .cfg(cfg_if)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state
  phase_t      pb_phase;
  logic [7:0]  lit_left;
  logic [7:0]  rep_count;
  logic [31:0] bytes_out;
  logic [31:0] seg_len;
  logic        overran;
  out_item_t   pending_pairs[$];

  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          holdoff_req;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned bytes_sent;
  int unsigned segments_started;
  int unsigned cfg_writes;

  function automatic void clear_segment();
    pb_phase = PH_HEADER;
    lit_left = 8'd0;
    rep_count = 8'd0;
    bytes_out = 32'd0;
    overran = 1'b0;
  endfunction

  function automatic void emit_copies(logic [7:0] v, int unsigned len, ref out_item_t q[$]);
    logic [31:0] room;
    int unsigned keep;
    int unsigned c;
    out_item_t r;
    room = seg_len - bytes_out;
    keep = (len < room) ? len : room;
    if (keep < len) overran = 1'b1;
    while (keep > 0) begin
      c = (keep >= 2) ? 2 : 1;
      bytes_out += c;
      keep -= c;
      r.byte_first = v;
      r.byte_second = (c == 2) ? v : 8'h00;
      r.byte_count = (c == 2) ? CNT_TWO : CNT_ONE;
      r.last_of_run = 1'b0;
      r.segment_done = (bytes_out == seg_len);
      r.length_error = overran;
      q.push_back(r);
    end
  endfunction

  function automatic void predict_decode(in_item_t it);
    out_item_t step_q[$];
    out_item_t r;
    logic err;
    if (it.segment_start) clear_segment();
    case (pb_phase)
      PH_LITERAL: begin
        emit_copies(it.in_byte, 1, step_q);
        lit_left = lit_left - 8'd1;
        if (lit_left == 8'd0) pb_phase = PH_HEADER;
      end
      PH_REPEAT: begin
        emit_copies(it.in_byte, rep_count, step_q);
        rep_count = 8'd0;
        pb_phase = PH_HEADER;
      end
      default: begin
        if (it.in_byte > HDR_NOP) begin
          rep_count = 8'(REPEAT_BASE - {1'b0, it.in_byte});
          pb_phase = PH_REPEAT;
        end else if (it.in_byte < HDR_NOP) begin
          lit_left = it.in_byte + 8'd1;
          pb_phase = PH_LITERAL;
        end
      end
    endcase
    if (it.segment_end) begin
      err = overran || (bytes_out != seg_len);
      if (step_q.size() == 0) begin
        r = '0;
        r.byte_count = CNT_NONE;
        r.segment_done = 1'b1;
        r.length_error = err;
        step_q.push_back(r);
      end else begin
        step_q[step_q.size() - 1].segment_done = 1'b1;
        step_q[step_q.size() - 1].length_error = err;
      end
      clear_segment();
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last_of_run = 1'b1;
    foreach (step_q[i]) pending_pairs.push_back(step_q[i]);
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got %0h want %0h", results_checked, what, got, want);
  endtask

  task automatic push_req(logic [7:0] b, bit s = 1'b0, bit e = 1'b0);
    in_item_t it;
    it = '{b, s, e};
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      enc_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    enc_if.valid <= 1'b1;
    enc_if.payload <= it;
    do @(posedge clk); while (!enc_if.ready);
    predict_decode(it);
    bytes_sent++;
    if (s) segments_started++;
  endtask

  // Drop the request, drain all pending results, then idle for the requested settle time.
  task automatic settle(int unsigned cycles);
    enc_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_target_len(logic [31:0] v);
    settle(SETTLE_CYCLES);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    do @(posedge clk); while (!cfg_if.ready);
    seg_len = v;
    cfg_writes++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_zero_length();
    push_req(8'h02, 1'b1, 1'b0);
    push_req(8'h11);
    push_req(8'h22, 1'b0, 1'b1);
  endtask

  task automatic test_length_overrun();
    write_target_len(32'd5);
    push_req(HDR_NOP, 1'b1, 1'b0);
    push_req(8'h01);
    push_req(8'h00);
    push_req(8'hFF);
    push_req(8'hFF);
    push_req(8'h5A);
    push_req(8'hFE);
    push_req(8'hC3);
    push_req(HDR_NOP, 1'b0, 1'b1);
  endtask

  task automatic test_open_run_at_end();
    write_target_len(32'hFFFF_FFFF);
    push_req(8'h81, 1'b1, 1'b0);
    push_req(8'h3C);
    push_req(8'h7F);
    push_req(8'hA5);
    push_req(8'h5A, 1'b0, 1'b1);
  endtask

  task automatic test_exact_fit();
    write_target_len(32'd3);
    push_req(8'h00, 1'b1, 1'b1);
    push_req(8'hFE, 1'b1, 1'b0);
    push_req(8'h77, 1'b0, 1'b1);
  endtask

  task automatic test_random_segments(int unsigned goal);
    in_item_t seg[$];
    int unsigned sent;
    int unsigned len;
    int unsigned total;
    int unsigned pick;
    int unsigned cut;
    logic [31:0] new_len;
    sent = 0;
    while (sent < goal) begin
      seg.delete();
      total = 0;
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 6))
          seg.push_back('{8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1))});
      end else begin
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAX_RUN) : $urandom_range(1, 6);
            seg.push_back('{8'(len - 1), 1'b0, 1'b0});
            repeat (len) seg.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
            total += len;
          end else if (pick < 9) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, MAX_RUN) : $urandom_range(2, 12);
            seg.push_back('{8'(257 - len), 1'b0, 1'b0});
            seg.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b0});
            total += len;
          end else begin
            seg.push_back('{HDR_NOP, 1'b0, 1'b0});
          end
        end
        seg[0].segment_start = 1'b1;
        case ($urandom_range(0, 7))
          0: seg.push_back('{8'($urandom_range(0, 255)), 1'b0, 1'b1});
          1: begin
            cut = $urandom_range(1, seg.size());
            while (seg.size() > cut) void'(seg.pop_back());
            seg[seg.size() - 1].segment_end = 1'b1;
          end
          2: ;
          default: seg[seg.size() - 1].segment_end = 1'b1;
        endcase
        if ($urandom_range(0, 1) == 1) begin
          case ($urandom_range(0, 5))
            0: new_len = total;
            1: new_len = (total > 0) ? total - 1 : 0;
            2: new_len = total + 1;
            3: new_len = 32'd0;
            4: new_len = 32'hFFFF_FFFF;
            default: new_len = $urandom();
          endcase
          write_target_len(new_len);
        end
      end
      foreach (seg[i]) push_req(seg[i].in_byte, seg[i].segment_start, seg[i].segment_end);
      sent += seg.size();
    end
  endtask

  task automatic test_backpressure();
    write_target_len(32'd400);
    holdoff_req = 1'b1;
    push_req(8'h81, 1'b1, 1'b0);
    push_req(8'hE7);
    push_req(8'h81);
    push_req(8'h18);
    push_req(8'h03);
    push_req(8'h01);
    push_req(8'h02);
    push_req(8'h04);
    push_req(8'h08);
    push_req(8'h81);
    push_req(8'h99);
    push_req(8'h81);
    push_req(8'h66, 1'b0, 1'b1);
  endtask

  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_segments(STREAM_ITEMS);
  endtask

  // Result receiver: random stalls plus one long hold-off on request
  initial begin : receiver
    int unsigned hold_n;
    hold_n = 0;
    dec_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_n = HOLDOFF_CYCLES;
      end else if (rx_idle_en && hold_n == 0 && $urandom_range(0, 5) == 0) begin
        hold_n = $urandom_range(1, 8);
      end
      if (hold_n > 0) begin
        dec_if.ready <= 1'b0;
        hold_n--;
      end else begin
        dec_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (!rst && dec_if.valid && dec_if.ready) begin
      got = dec_if.payload;
      results_checked++;
      if (pending_pairs.size() == 0) begin
        report_mismatch("unexpected result", got, 0);
      end else begin
        want = pending_pairs.pop_front();
        if (got.byte_first !== want.byte_first)
          report_mismatch("byte_first", got.byte_first, want.byte_first);
        if (got.byte_second !== want.byte_second)
          report_mismatch("byte_second", got.byte_second, want.byte_second);
        if (got.byte_count !== want.byte_count)
          report_mismatch("byte_count", got.byte_count, want.byte_count);
        if (got.last_of_run !== want.last_of_run)
          report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
        if (got.segment_done !== want.segment_done)
          report_mismatch("segment_done", got.segment_done, want.segment_done);
        if (got.length_error !== want.length_error)
          report_mismatch("length_error", got.length_error, want.length_error);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((enc_if.valid && enc_if.ready) || (dec_if.valid && dec_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("stalled for %0d cycles with %0d results pending", quiet, pending_pairs.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    enc_if.valid = 1'b0;
    enc_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    holdoff_req = 1'b0;
    mismatches = 0;
    results_checked = 0;
    bytes_sent = 0;
    segments_started = 0;
    cfg_writes = 0;
    seg_len = 32'd0;
    clear_segment();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_length();
    test_length_overrun();
    test_open_run_at_end();
    test_exact_fit();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_random_segments(RANDOM_ITEMS);
    test_backpressure();
    test_streaming();
    settle(TAIL_CYCLES);

    $display("sent %0d encoded bytes over %0d segments with %0d length settings",
             bytes_sent, segments_started, cfg_writes);
    $display("checked %0d decoded results, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/psd_pkg.sv
hw/rtl/psd_if.sv
hw/rtl/psd_ctrl.sv
hw/rtl/psd_datapath.sv
hw/rtl/packbits_segment_decoder.sv
test/packbits_segment_decoder_tb.sv
